>>> rtl/rsam_pkg.sv
// Shared types and constants for the RAID-5 stripe address map.
// Used by every module under rtl/; depends on nothing else.
package rsam_pkg;

  // Field widths
  localparam int SECTOR_W   = 40;
  localparam int MEMBER_W   = 4;
  localparam int COUNT_W    = MEMBER_W + 1;
  localparam int START_W    = 32;
  localparam int LAYOUT_W   = 2;

  // Chunk geometry: 1024 sectors per chunk
  localparam int CHUNK_LOG2 = 10;
  localparam int CHUNK_W    = SECTOR_W - CHUNK_LOG2;

  // Divider geometry: quotient digits of DIGIT_W bits, one digit per stage
  localparam int DIGIT_W    = 4;
  localparam int DIV_STAGES = (CHUNK_W + DIGIT_W - 1) / DIGIT_W;
  localparam int DIV_W      = DIV_STAGES * DIGIT_W;

  // Data member limits
  localparam logic [MEMBER_W-1:0] DM_MIN = MEMBER_W'(2);

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_MEMBERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_LAYOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 2'd2;

  // Configuration reset values
  localparam logic [MEMBER_W-1:0] RST_DATA_MEMBERS = 4'd4;
  localparam logic [LAYOUT_W-1:0] RST_PARITY_LAYOUT = 2'd3;
  localparam logic [START_W-1:0]  RST_DATA_START = 32'd4096;

  // Parity layouts
  localparam logic [LAYOUT_W-1:0] LAYOUT_LEFT_SYM   = 2'd0;
  localparam logic [LAYOUT_W-1:0] LAYOUT_RIGHT_SYM  = 2'd1;
  localparam logic [LAYOUT_W-1:0] LAYOUT_RIGHT_ASYM = 2'd2;
  localparam logic [LAYOUT_W-1:0] LAYOUT_LEFT_ASYM  = 2'd3;

  // Item state carried down the divider pipeline.
  // chunk_quot: unconsumed chunk bits at the top, quotient digits shift in at the bottom.
  typedef struct packed {
    logic [DIV_W-1:0]      chunk_quot;
    logic [MEMBER_W-1:0]   rem_dm;
    logic [MEMBER_W-1:0]   rem_n;
    logic [CHUNK_LOG2-1:0] pos;
  } div_item_t;

endpackage

>>> rtl/rsam_div_stage.sv
// One stage of the stripe divider: retires one quotient digit of chunk / data_members
// and folds that digit into stripe % members. Depends on rsam_pkg.
module rsam_div_stage (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  rsam_pkg::div_item_t                item_i,
  input  logic [rsam_pkg::MEMBER_W-1:0]      dm_i,
  input  logic [rsam_pkg::COUNT_W-1:0]       n_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output rsam_pkg::div_item_t                item_o
);

  logic                valid_r;
  rsam_pkg::div_item_t item_r;
  rsam_pkg::div_item_t item_nxt;

  // Restoring division by dm, bit by bit, with the quotient bits reduced mod n
  always_comb begin
    logic [rsam_pkg::DIV_W-1:0]    acc;
    logic [rsam_pkg::MEMBER_W-1:0] rd;
    logic [rsam_pkg::MEMBER_W-1:0] rn;
    logic [rsam_pkg::COUNT_W-1:0]  td;
    logic [rsam_pkg::COUNT_W-1:0]  tn;
    logic                          qb;
    acc = item_i.chunk_quot;
    rd  = item_i.rem_dm;
    rn  = item_i.rem_n;
    for (int k = 0; k < rsam_pkg::DIGIT_W; k++) begin
      td = {rd, acc[rsam_pkg::DIV_W-1]};
      qb = (td >= {1'b0, dm_i});
      if (qb) begin
        td = td - {1'b0, dm_i};
      end
      rd  = td[rsam_pkg::MEMBER_W-1:0];
      acc = {acc[rsam_pkg::DIV_W-2:0], qb};
      tn  = {rn, qb};
      if (tn >= n_i) begin
        tn = tn - n_i;
      end
      rn = tn[rsam_pkg::MEMBER_W-1:0];
    end
    item_nxt.chunk_quot = acc;
    item_nxt.rem_dm     = rd;
    item_nxt.rem_n      = rn;
    item_nxt.pos        = item_i.pos;
  end

  // Take a new item when empty or when the next stage drains this one
  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      item_r <= item_nxt;
    end
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule

>>> rtl/rsam_map_out.sv
// Output stage: places parity and data on the members per the layout and forms
// the member sector, into the output register. Depends on rsam_pkg.
module rsam_map_out (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  rsam_pkg::div_item_t                item_i,
  input  logic [rsam_pkg::COUNT_W-1:0]       n_i,
  input  logic [rsam_pkg::LAYOUT_W-1:0]      layout_i,
  input  logic [rsam_pkg::START_W-1:0]       start_i,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rsam_pkg::MEMBER_W-1:0]      out_member_index,
  output logic [rsam_pkg::SECTOR_W-1:0]      out_member_sector,
  output logic [rsam_pkg::MEMBER_W-1:0]      out_parity_index,
  output logic [rsam_pkg::SECTOR_W-1:0]      out_stripe_index
);

  logic                            valid_r;
  logic [rsam_pkg::MEMBER_W-1:0]   member_r;
  logic [rsam_pkg::SECTOR_W-1:0]   msec_r;
  logic [rsam_pkg::MEMBER_W-1:0]   parity_r;
  logic [rsam_pkg::SECTOR_W-1:0]   stripe_r;

  logic [rsam_pkg::MEMBER_W-1:0]   member_nxt;
  logic [rsam_pkg::SECTOR_W-1:0]   msec_nxt;
  logic [rsam_pkg::MEMBER_W-1:0]   parity_nxt;
  logic [rsam_pkg::SECTOR_W-1:0]   stripe_nxt;

  logic [rsam_pkg::CHUNK_W-1:0]    stripe;
  logic [rsam_pkg::MEMBER_W-1:0]   slot;
  logic [rsam_pkg::MEMBER_W-1:0]   srot;
  logic [rsam_pkg::MEMBER_W-1:0]   par_left;
  logic [rsam_pkg::COUNT_W-1:0]    sym_sum;
  logic [rsam_pkg::MEMBER_W-1:0]   member_sym;
  logic [rsam_pkg::MEMBER_W-1:0]   member_asym;

  assign stripe = item_i.chunk_quot[rsam_pkg::CHUNK_W-1:0];
  assign slot   = item_i.rem_dm;
  assign srot   = item_i.rem_n;

  // Parity counts down from the last member for the left layouts
  assign par_left = rsam_pkg::MEMBER_W'(n_i - rsam_pkg::COUNT_W'(1) - {1'b0, srot});

  always_comb begin
    case (layout_i)
      rsam_pkg::LAYOUT_LEFT_SYM,
      rsam_pkg::LAYOUT_LEFT_ASYM: parity_nxt = par_left;
      default:                    parity_nxt = srot;
    endcase
  end

  // Symmetric: data follows parity and wraps; asymmetric: data skips the parity member
  always_comb begin
    sym_sum = {1'b0, parity_nxt} + rsam_pkg::COUNT_W'(1) + {1'b0, slot};
    if (sym_sum >= n_i) begin
      sym_sum = sym_sum - n_i;
    end
    member_sym  = sym_sum[rsam_pkg::MEMBER_W-1:0];
    member_asym = slot + rsam_pkg::MEMBER_W'(slot >= parity_nxt);
  end

  always_comb begin
    case (layout_i)
      rsam_pkg::LAYOUT_LEFT_SYM,
      rsam_pkg::LAYOUT_RIGHT_SYM: member_nxt = member_sym;
      default:                    member_nxt = member_asym;
    endcase
  end

  // Member sector: start + stripe * chunk + offset; the offset fills the low bits
  assign msec_nxt   = rsam_pkg::SECTOR_W'(start_i) + {stripe, item_i.pos};
  assign stripe_nxt = rsam_pkg::SECTOR_W'(stripe);

  assign ready_o = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      member_r <= member_nxt;
      msec_r   <= msec_nxt;
      parity_r <= parity_nxt;
      stripe_r <= stripe_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_member_index  = member_r;
  assign out_member_sector = msec_r;
  assign out_parity_index  = parity_r;
  assign out_stripe_index  = stripe_r;

endmodule

>>> rtl/raid5_stripe_address_map_top.sv
// RAID-5 stripe address map: maps a logical sector to member disk, member sector,
// parity member and stripe. Depends on rsam_pkg, rsam_div_stage and rsam_map_out.
//
// Usage:
//   Input channel in_valid/in_ready carries one logical sector per item.
//   Result channel out_valid/out_ready returns one item per input, in order:
//   member index, member sector, parity member index and stripe index.
//   cfg_wr_en/cfg_index/cfg_data write data_members (0), parity_layout (1)
//   and data_start_sector (2); index 3 is ignored. Write only while idle.
// Timing:
//   Eight divider stages, each retiring one 4-bit digit of chunk / data_members
//   and reducing the stripe mod member count, then one output stage; each stage
//   registers its item. One item per cycle is sustained while out_ready is
//   high. The divider digit chain in each stage sets the clock.
// Reset and stall:
//   Reset empties the pipeline and loads data_members 4, left-asymmetric layout
//   and data start 4096. Every stage holds its item while the one after it is
//   full and stalled; empty stages keep filling, so a stalled receiver blocks
//   the input only once the whole pipeline is full.
module raid5_stripe_address_map_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rsam_pkg::SECTOR_W-1:0]       in_logical_sector,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rsam_pkg::MEMBER_W-1:0]       out_member_index,
  output logic [rsam_pkg::SECTOR_W-1:0]       out_member_sector,
  output logic [rsam_pkg::MEMBER_W-1:0]       out_parity_index,
  output logic [rsam_pkg::SECTOR_W-1:0]       out_stripe_index,
  input  logic                                cfg_wr_en,
  input  logic [rsam_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rsam_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NS = rsam_pkg::DIV_STAGES;

  logic [rsam_pkg::MEMBER_W-1:0]  dm_r;
  logic [rsam_pkg::LAYOUT_W-1:0]  layout_r;
  logic [rsam_pkg::START_W-1:0]   start_r;

  logic [rsam_pkg::MEMBER_W-1:0]  dm_eff;
  logic [rsam_pkg::COUNT_W-1:0]   n_members;

  rsam_pkg::div_item_t            item_in;
  rsam_pkg::div_item_t            items [NS+1];
  logic [NS:0]                    valids;
  logic [NS:0]                    readys;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dm_r     <= rsam_pkg::RST_DATA_MEMBERS;
      layout_r <= rsam_pkg::RST_PARITY_LAYOUT;
      start_r  <= rsam_pkg::RST_DATA_START;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rsam_pkg::CFG_DATA_MEMBERS:  dm_r     <= cfg_data[rsam_pkg::MEMBER_W-1:0];
        rsam_pkg::CFG_PARITY_LAYOUT: layout_r <= cfg_data[rsam_pkg::LAYOUT_W-1:0];
        rsam_pkg::CFG_DATA_START:    start_r  <= cfg_data[rsam_pkg::START_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp data members to at least two; the 4-bit field cannot exceed the maximum
  assign dm_eff    = (dm_r < rsam_pkg::DM_MIN) ? rsam_pkg::DM_MIN : dm_r;
  assign n_members = {1'b0, dm_eff} + rsam_pkg::COUNT_W'(1);

  // Split the sector into chunk number and offset within the chunk
  always_comb begin
    item_in.chunk_quot = rsam_pkg::DIV_W'(in_logical_sector[rsam_pkg::SECTOR_W-1:
                                                            rsam_pkg::CHUNK_LOG2]);
    item_in.rem_dm     = '0;
    item_in.rem_n      = '0;
    item_in.pos        = in_logical_sector[rsam_pkg::CHUNK_LOG2-1:0];
  end

  assign items[0]  = item_in;
  assign valids[0] = in_valid;
  assign in_ready  = readys[0];

  // Divider pipeline
  for (genvar s = 0; s < NS; s++) begin : g_div
    rsam_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (valids[s]),
      .ready_o (readys[s]),
      .item_i  (items[s]),
      .dm_i    (dm_eff),
      .n_i     (n_members),
      .valid_o (valids[s+1]),
      .ready_i (readys[s+1]),
      .item_o  (items[s+1])
    );
  end

  // Layout and member sector, registered at the output
  rsam_map_out u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .valid_i           (valids[NS]),
    .ready_o           (readys[NS]),
    .item_i            (items[NS]),
    .n_i               (n_members),
    .layout_i          (layout_r),
    .start_i           (start_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_member_index  (out_member_index),
    .out_member_sector (out_member_sector),
    .out_parity_index  (out_parity_index),
    .out_stripe_index  (out_stripe_index)
  );

endmodule
